[rtl/gqi_pkg.sv]
// Shared constants and a saturation function for the gyro quaternion integrator.
// No dependencies.
`timescale 1ns / 1ps
package gqi_pkg;
    localparam int unsigned RATE_CONST = 585635;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
    localparam logic signed [63:0] H_LIMIT = 64'sd4294967295;
    localparam logic [0:0] REG_TIME_STEP = 1'b0;
    localparam logic [0:0] REG_REPEAT    = 1'b1;

    // signed 64-bit saturate to 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction
endpackage

[rtl/gyro_quaternion_integrator_unit.sv]
// Top level of the gyro quaternion integrator: sequencer, shared multiplier,
// bit-serial square root and divider. Depends on gqi_pkg.
`timescale 1ns / 1ps
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, rate_x/y/z            | sink
//  out     | out_valid, out_stall, quat_w/x/y/z        | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
// One sample goes from its accept to the result beat through: a product, a low-part and a
// high-part step per axis for the half angles, then per pass 12 multiply-accumulates and four
// squares on the shared 33x33 multiplier, a 32-step root, a setup step plus 63 divide steps
// (all four components in parallel) and one pass-control step. A zero norm skips 63 steps.
// The block takes no new sample until the result beat has left the output register.
// Reset gives identity attitude and default registers. cfg_ready is always high.
module gyro_quaternion_integrator_unit
    import gqi_pkg::*;
#(
    parameter int QUAT_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            rate_x,
    input  logic signed [15:0]            rate_y,
    input  logic signed [15:0]            rate_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [QUAT_WIDTH-1:0]  quat_w,
    output logic signed [QUAT_WIDTH-1:0]  quat_x,
    output logic signed [QUAT_WIDTH-1:0]  quat_y,
    output logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [23:0]                   cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_HP, S_HL, S_HM, S_MUL, S_ACC, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [23:0]            tstep_reg;
    logic [4:0]             rep_reg;
    logic [4:0]             pass_reg;
    logic signed [31:0]     att_reg [4];
    logic signed [16:0]     rate_reg [3];
    logic signed [63:0]     h_reg [3];
    logic signed [63:0]     n_reg [4];
    logic [1:0]             ax_reg;
    logic [3:0]             mi_reg;
    logic signed [63:0]     prod_reg;
    logic [63:0]            s_reg;
    logic [63:0]            rem_reg;
    logic [63:0]            res_reg;
    logic [63:0]            bit_reg;
    logic [5:0]             cnt_reg;
    logic [62:0]            dr_reg [4];
    logic [31:0]            dq_reg [4];
    logic [31:0]            r_reg;
    logic                   out_valid_reg;
    logic signed [QUAT_WIDTH-1:0] qo_reg [4];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign quat_w = qo_reg[0];
    assign quat_x = qo_reg[1];
    assign quat_y = qo_reg[2];
    assign quat_z = qo_reg[3];

    // product schedule: component i gets sign*att[a]*h[b]
    logic [1:0] m_comp, m_att, m_h;
    logic       m_neg;
    always_comb
    begin
        m_comp = mi_reg[3:2] == 2'd0 ? 2'd0 : 2'd0;
        m_att = 2'd0; m_h = 2'd0; m_neg = 1'b0; m_comp = 2'd0;
        case (mi_reg)
            4'd0:  begin m_comp = 2'd0; m_att = 2'd1; m_h = 2'd0; m_neg = 1'b1; end
            4'd1:  begin m_comp = 2'd0; m_att = 2'd2; m_h = 2'd1; m_neg = 1'b1; end
            4'd2:  begin m_comp = 2'd0; m_att = 2'd3; m_h = 2'd2; m_neg = 1'b1; end
            4'd3:  begin m_comp = 2'd1; m_att = 2'd0; m_h = 2'd0; m_neg = 1'b0; end
            4'd4:  begin m_comp = 2'd1; m_att = 2'd2; m_h = 2'd2; m_neg = 1'b0; end
            4'd5:  begin m_comp = 2'd1; m_att = 2'd3; m_h = 2'd1; m_neg = 1'b1; end
            4'd6:  begin m_comp = 2'd2; m_att = 2'd0; m_h = 2'd1; m_neg = 1'b0; end
            4'd7:  begin m_comp = 2'd2; m_att = 2'd1; m_h = 2'd2; m_neg = 1'b1; end
            4'd8:  begin m_comp = 2'd2; m_att = 2'd3; m_h = 2'd0; m_neg = 1'b0; end
            4'd9:  begin m_comp = 2'd3; m_att = 2'd0; m_h = 2'd2; m_neg = 1'b0; end
            4'd10: begin m_comp = 2'd3; m_att = 2'd1; m_h = 2'd1; m_neg = 1'b0; end
            4'd11: begin m_comp = 2'd3; m_att = 2'd2; m_h = 2'd0; m_neg = 1'b1; end
            default: begin m_comp = 2'd0; m_att = 2'd0; m_h = 2'd0; m_neg = 1'b0; end
        endcase
    end

    // magnitudes of the four sums
    logic [63:0] mag [4];

    // shared multiplier: operands chosen by state
    // half angle p*C is split as (p>>24)*C*2^24 + (p mod 2^24)*C
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_HP:
            begin
                mul_a = 33'(rate_reg[ax_reg]);
                mul_b = $signed({9'd0, tstep_reg});
            end
            S_HL:
            begin
                mul_a = $signed({9'd0, h_reg[ax_reg][23:0]});
                mul_b = 33'(RATE_CONST);
            end
            S_HM:
            begin
                mul_a = 33'($signed(h_reg[ax_reg][40:24]));
                mul_b = 33'(RATE_CONST);
            end
            S_MUL:
            begin
                mul_a = 33'(att_reg[m_att]);
                mul_b = h_reg[m_h][32:0];
            end
            S_SQ:
            begin
                mul_a = $signed({1'b0, mag[ax_reg][31:0]});
                mul_b = $signed({1'b0, mag[ax_reg][31:0]});
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // normalising shift: largest magnitude of the four sums
    logic [63:0] mmax;
    logic [1:0]  kshift;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mag[i] = n_reg[i][63] ? 64'(-n_reg[i]) : 64'(n_reg[i]);
        mmax = mag[0] | mag[1] | mag[2] | mag[3];
        if (mmax[33]) kshift = 2'd3;
        else if (mmax[32]) kshift = 2'd2;
        else if (mmax[31]) kshift = 2'd1;
        else kshift = 2'd0;
        // or-ing marks the top bit of the largest magnitude exactly
    end

    logic [63:0] root_trial;
    logic [62:0] dr_trial [4];
    logic signed [63:0] hround;
    always_comb
    begin
        root_trial = res_reg + bit_reg;
        hround = prod_reg + 64'sd8388608;
        for (int i = 0; i < 4; i++)
            dr_trial[i] = dr_reg[i] - 63'({r_reg, 31'd0} >> 31);
    end

    // output formatting
    function automatic logic signed [QUAT_WIDTH-1:0] fmt(input logic signed [31:0] q);
        logic signed [63:0] v;
        logic signed [63:0] top;
        v = 64'(q);
        top = 64'sd0;
        if (QUAT_WIDTH <= 32)
        begin
            if (QUAT_WIDTH < 32)
                v = (v + (64'sd1 <<< (31 - QUAT_WIDTH))) >>> (32 - QUAT_WIDTH);
            top = (64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1;
            if (v > top) v = top;
            else if (v < -top - 64'sd1) v = -top - 64'sd1;
        end
        else
            v = v <<< (QUAT_WIDTH - 32);
        fmt = v[QUAT_WIDTH-1:0];
    endfunction

    logic signed [63:0] hsh;
    logic signed [63:0] rnd;
    always_comb
    begin
        // high part exact, low part carries the rounding
        hsh = $signed(mul_p[63:0]) + (hround >>> 24);
        rnd = (prod_reg + 64'sd536870912) >>> 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tstep_reg     <= 24'd419430;
            rep_reg       <= 5'd1;
            out_valid_reg <= 1'b0;
            att_reg[0]    <= 32'sd1073741824;
            att_reg[1]    <= '0;
            att_reg[2]    <= '0;
            att_reg[3]    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TIME_STEP: tstep_reg <= cfg_data;
                    REG_REPEAT:    rep_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        rate_reg[0] <= 17'(rate_x);
                        rate_reg[1] <= -17'(rate_y);
                        rate_reg[2] <= -17'(rate_z);
                        ax_reg   <= 2'd0;
                        pass_reg <= (rep_reg == 5'd0) ? 5'd1 :
                                    (rep_reg > 5'd16) ? 5'd16 : rep_reg;
                        state_reg <= S_HP;
                    end
                S_HP:
                begin
                    // p = rate * dt, fits in 41 bits
                    h_reg[ax_reg] <= 64'(mul_p);
                    state_reg <= S_HL;
                end
                S_HL:
                begin
                    // low 24 bits of p times the rate constant
                    prod_reg <= mul_p[63:0];
                    state_reg <= S_HM;
                end
                S_HM:
                begin
                    if (hsh > H_LIMIT) h_reg[ax_reg] <= H_LIMIT;
                    else if (hsh < -H_LIMIT) h_reg[ax_reg] <= -H_LIMIT;
                    else h_reg[ax_reg] <= hsh;
                    if (ax_reg == 2'd2)
                    begin
                        mi_reg <= '0;
                        for (int i = 0; i < 4; i++) n_reg[i] <= 64'(att_reg[i]);
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                        state_reg <= S_HP;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= mul_p[63:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    n_reg[m_comp] <= m_neg ? n_reg[m_comp] - rnd : n_reg[m_comp] + rnd;
                    if (mi_reg == 4'd11)
                        state_reg <= S_NORM;
                    else
                    begin
                        mi_reg <= mi_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_NORM:
                begin
                    for (int i = 0; i < 4; i++) n_reg[i] <= n_reg[i] >>> kshift;
                    s_reg  <= '0;
                    ax_reg <= 2'd0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    s_reg <= s_reg + mul_p[63:0];
                    if (ax_reg == 2'd3)
                    begin
                        rem_reg <= s_reg + mul_p[63:0];
                        res_reg <= '0;
                        bit_reg <= 64'd1 << 62;
                        cnt_reg <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end
                S_ROOT:
                begin
                    if (rem_reg >= root_trial)
                    begin
                        rem_reg <= rem_reg - root_trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 6'd31)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_DIV:
                begin
                    // setup step first (count zero), then 63 restoring steps on (|c|<<30)+r/2
                    if (cnt_reg == 6'd0)
                    begin
                        r_reg <= res_reg[31:0];
                        if (res_reg == 64'd0)
                        begin
                            att_reg[0] <= 32'sd1073741824;
                            att_reg[1] <= '0;
                            att_reg[2] <= '0;
                            att_reg[3] <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                dr_reg[i] <= '0;
                                dq_reg[i] <= '0;
                            end
                            s_reg <= '0;
                            cnt_reg <= 6'd1;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin : dstep
                            logic [63:0] num;
                            logic [63:0] rem2;
                            logic [31:0] qn;
                            num = ({mag[i][31:0], 30'd0} + 64'(r_reg >> 1))
                                  & 64'h7fff_ffff_ffff_ffff;
                            rem2 = {dr_reg[i], num[6'd62 - (cnt_reg - 6'd1)]};
                            if (rem2 >= 64'(r_reg))
                            begin
                                dr_reg[i] <= 63'(rem2 - 64'(r_reg));
                                qn = {dq_reg[i][30:0], 1'b1};
                            end
                            else
                            begin
                                dr_reg[i] <= 63'(rem2);
                                qn = {dq_reg[i][30:0], 1'b0};
                            end
                            dq_reg[i] <= qn;
                            // last step: quotient complete, apply the sign
                            if (cnt_reg == 6'd63)
                                att_reg[i] <= n_reg[i][63] ?
                                    sat32(-64'({1'b0, qn})) :
                                    sat32(64'({1'b0, qn}));
                        end
                        if (cnt_reg == 6'd63)
                            state_reg <= S_OUT;
                        else
                            cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_OUT:
                begin
                    if (pass_reg > 5'd1)
                    begin
                        pass_reg <= pass_reg - 5'd1;
                        mi_reg <= '0;
                        for (int i = 0; i < 4; i++) n_reg[i] <= 64'(att_reg[i]);
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++) qo_reg[i] <= fmt(att_reg[i]);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{dr_trial[0], dr_trial[1], dr_trial[2], dr_trial[3], ONE_Q30, RATE_CONST};
endmodule
